// File: hdl/srsw_pkg.sv
// Package for the selective-repeat sender window.
// Types, constants and codes shared by the cells, the controller and the top level.
`default_nettype none
package srsw_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int WIN_W      = IDX_W + 1;
    localparam int SEG_BYTES  = 1456;
    localparam int OFF_W      = 44;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_FILE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_START,
        M_ACK,
        M_TICK
    } t_mode;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [31:0] seq_num;
        logic [10:0] seg_length;
        logic        is_resend;
        logic        transfer_done;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        acked;
        logic [31:0] sent_time;
    } t_slot;

    typedef struct packed {
        logic             start_clear;
        logic             mark;
        logic [IDX_W-1:0] mark_idx;
        logic             rotate;
        logic             drop;
        logic             restamp;
        logic [31:0]      now;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: hdl/srsw_cell.sv
// One window slot of the ring: acknowledged flag and send time.
// Uses srsw_pkg for the slot and control types.
`default_nettype none
module srsw_cell (
    input  wire logic                   i_clk,
    input  wire srsw_pkg::t_cell_ctl    i_ctl,
    input  wire logic [srsw_pkg::IDX_W-1:0] i_idx,
    input  wire srsw_pkg::t_slot        i_next,
    output srsw_pkg::t_slot             o_slot
);

    srsw_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_clear) begin
            r_slot.acked     <= 1'b0;
            r_slot.sent_time <= i_ctl.now;
        end else if (i_ctl.mark && (i_ctl.mark_idx == i_idx)) begin
            r_slot.acked <= 1'b1;
        end else if (i_ctl.rotate) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

// File: hdl/srsw_ctrl.sv
// Sequencer of the sender window: registers, head tracking, slot scan and result output.
// Uses srsw_pkg; drives the cell ring through a t_cell_ctl struct.
`default_nettype none
module srsw_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire srsw_pkg::t_in_item      i_in_item,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output srsw_pkg::t_out_item          o_out_item,
    input  wire logic                    i_out_stall,
    input  wire logic                    i_cfg_valid,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data,
    input  wire srsw_pkg::t_slot         i_head_slot,
    output srsw_pkg::t_cell_ctl          o_ctl,
    output logic [srsw_pkg::WIN_W-1:0]   o_win
);

    localparam logic [srsw_pkg::OFF_W-1:0] SEG_OFF = srsw_pkg::OFF_W'(srsw_pkg::SEG_BYTES);

    srsw_pkg::t_state r_state, n_state;
    srsw_pkg::t_mode  r_mode, n_mode;

    logic [4:0]  r_window_size;
    logic [15:0] r_timeout;
    logic [31:0] r_file;

    logic [srsw_pkg::WIN_W-1:0] r_win, n_win;
    logic [31:0] r_head, n_head;
    logic [srsw_pkg::OFF_W-1:0] r_head_off, n_head_off;
    logic [srsw_pkg::OFF_W-1:0] r_scan_off, n_scan_off;
    logic [31:0] r_now, n_now;
    logic        r_running, n_running;
    logic [srsw_pkg::WIN_W-1:0] r_k, n_k;
    logic [srsw_pkg::WIN_W-1:0] r_thresh, n_thresh;
    logic [srsw_pkg::IDX_W-1:0] r_i, n_i;

    logic                 r_pend, n_pend;
    srsw_pkg::t_out_item  r_pend_item, n_pend_item;
    logic                 r_ovalid, n_ovalid;
    srsw_pkg::t_out_item  r_oitem, n_oitem;

    logic        out_free;
    logic        accept;
    logic [31:0] ack_off;
    logic [srsw_pkg::WIN_W-1:0] win_clamped;
    logic [31:0] rem;
    logic [10:0] len;
    logic        len_nz;
    logic [31:0] age;
    logic        emit;
    srsw_pkg::t_out_item emit_item;
    srsw_pkg::t_out_item done_item;

    assign out_free = !r_ovalid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign ack_off  = i_in_item.ack_seq - r_head;

    always_comb begin
        if (r_window_size == 5'd0) begin
            win_clamped = srsw_pkg::WIN_W'(1);
        end else if (32'(r_window_size) > 32'(srsw_pkg::MAX_WINDOW)) begin
            win_clamped = srsw_pkg::WIN_W'(srsw_pkg::MAX_WINDOW);
        end else begin
            win_clamped = srsw_pkg::WIN_W'(r_window_size);
        end
    end

    always_comb begin
        len_nz = r_scan_off < {12'd0, r_file};
        rem    = r_file - r_scan_off[31:0];
        if (rem > 32'(srsw_pkg::SEG_BYTES)) begin
            len = 11'(srsw_pkg::SEG_BYTES);
        end else begin
            len = rem[10:0];
        end
        age = r_now - i_head_slot.sent_time;
        emit_item.seq_num       = r_head + 32'(r_i);
        emit_item.seg_length    = len;
        emit_item.is_resend     = (r_mode == srsw_pkg::M_TICK);
        emit_item.transfer_done = 1'b0;
        emit_item.last          = 1'b0;
        done_item               = '0;
        done_item.transfer_done = 1'b1;
        done_item.last          = 1'b1;
        emit = ({1'b0, r_i} >= r_thresh) && len_nz &&
               ((r_mode != srsw_pkg::M_TICK) ||
                (!i_head_slot.acked && (age > {16'd0, r_timeout})));
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_win       = r_win;
        n_head      = r_head;
        n_head_off  = r_head_off;
        n_scan_off  = r_scan_off;
        n_now       = r_now;
        n_running   = r_running;
        n_k         = r_k;
        n_thresh    = r_thresh;
        n_i         = r_i;
        n_pend      = r_pend;
        n_pend_item = r_pend_item;
        n_ovalid    = r_ovalid && i_out_stall;
        n_oitem     = r_oitem;
        o_ctl       = '0;
        o_ctl.now   = r_now;
        o_in_stall  = (r_state != srsw_pkg::S_IDLE);

        case (r_state)
            srsw_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in_item.cmd)
                        srsw_pkg::CMD_START: begin
                            n_win             = win_clamped;
                            n_head            = '0;
                            n_head_off        = '0;
                            o_ctl.start_clear = 1'b1;
                            if (r_file == 32'd0) begin
                                n_running = 1'b0;
                                n_state   = srsw_pkg::S_DONE;
                            end else begin
                                n_running  = 1'b1;
                                n_mode     = srsw_pkg::M_START;
                                n_thresh   = '0;
                                n_i        = '0;
                                n_scan_off = '0;
                                n_pend     = 1'b0;
                                n_state    = srsw_pkg::S_SCAN;
                            end
                        end
                        srsw_pkg::CMD_ACK: begin
                            if (r_running && (ack_off < 32'(r_win))) begin
                                o_ctl.mark     = 1'b1;
                                o_ctl.mark_idx = ack_off[srsw_pkg::IDX_W-1:0];
                                if (ack_off == 32'd0) begin
                                    n_k     = '0;
                                    n_state = srsw_pkg::S_DROP;
                                end
                            end
                        end
                        srsw_pkg::CMD_TICK: begin
                            n_now = r_now + 32'd1;
                            if (r_running) begin
                                n_mode     = srsw_pkg::M_TICK;
                                n_thresh   = '0;
                                n_i        = '0;
                                n_scan_off = r_head_off;
                                n_pend     = 1'b0;
                                n_state    = srsw_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            srsw_pkg::S_DROP: begin
                if (i_head_slot.acked) begin
                    o_ctl.rotate = 1'b1;
                    o_ctl.drop   = 1'b1;
                    n_head       = r_head + 32'd1;
                    n_head_off   = r_head_off + SEG_OFF;
                    n_k          = r_k + srsw_pkg::WIN_W'(1);
                end else if (r_head_off >= {12'd0, r_file}) begin
                    n_running = 1'b0;
                    n_state   = srsw_pkg::S_DONE;
                end else begin
                    n_mode     = srsw_pkg::M_ACK;
                    n_thresh   = r_win - r_k;
                    n_i        = '0;
                    n_scan_off = r_head_off;
                    n_pend     = 1'b0;
                    n_state    = srsw_pkg::S_SCAN;
                end
            end
            srsw_pkg::S_SCAN: begin
                if (out_free) begin
                    o_ctl.rotate  = 1'b1;
                    o_ctl.restamp = emit && (r_mode == srsw_pkg::M_TICK);
                    if (emit) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1;
                            n_oitem  = r_pend_item;
                        end
                        n_pend      = 1'b1;
                        n_pend_item = emit_item;
                    end
                    n_i        = r_i + srsw_pkg::IDX_W'(1);
                    n_scan_off = r_scan_off + SEG_OFF;
                    if ({1'b0, r_i} == r_win - srsw_pkg::WIN_W'(1)) begin
                        n_state = srsw_pkg::S_FLUSH;
                    end
                end
            end
            srsw_pkg::S_FLUSH: begin
                if (!r_pend) begin
                    n_state = srsw_pkg::S_IDLE;
                end else if (out_free) begin
                    n_ovalid     = 1'b1;
                    n_oitem      = r_pend_item;
                    n_oitem.last = 1'b1;
                    n_pend       = 1'b0;
                    n_state      = srsw_pkg::S_IDLE;
                end
            end
            srsw_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oitem  = done_item;
                    n_state  = srsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srsw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= srsw_pkg::S_IDLE;
            r_mode        <= srsw_pkg::M_START;
            r_window_size <= 5'd16;
            r_timeout     <= 16'd500;
            r_file        <= '0;
            r_win         <= srsw_pkg::WIN_W'(srsw_pkg::MAX_WINDOW);
            r_head        <= '0;
            r_head_off    <= '0;
            r_now         <= '0;
            r_running     <= 1'b0;
            r_pend        <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_win      <= n_win;
            r_head     <= n_head;
            r_head_off <= n_head_off;
            r_now      <= n_now;
            r_running  <= n_running;
            r_pend     <= n_pend;
            r_ovalid   <= n_ovalid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    srsw_pkg::CFG_WINDOW:  r_window_size <= i_cfg_data[4:0];
                    srsw_pkg::CFG_TIMEOUT: r_timeout     <= i_cfg_data[15:0];
                    srsw_pkg::CFG_FILE:    r_file        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_off  <= n_scan_off;
        r_k         <= n_k;
        r_thresh    <= n_thresh;
        r_i         <= n_i;
        r_pend_item <= n_pend_item;
        r_oitem     <= n_oitem;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
    assign o_win       = r_win;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_out_stall |=> r_ovalid && $stable(r_oitem))
        else $error("result changed while stalled");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oitem.transfer_done |->
        r_oitem.seq_num == 32'd0 && r_oitem.seg_length == 11'd0 && r_oitem.last)
        else $error("done result carries segment fields");
    a_drop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srsw_pkg::S_DROP |-> r_k <= r_win)
        else $error("window slid past its size");

endmodule
`default_nettype wire

// File: hdl/selective_repeat_sender_window_top.sv
// Sender window of a selective-repeat transfer: one item (start, acknowledgement or tick) is
// taken at a time. A start with a non-empty file, or a tick while running, walks the slot ring
// once, one slot per cycle while results are not stalled; an acknowledgement of the head first
// slides the window past the acknowledged slots, then walks the ring unless the file is done. No item
// is taken while a walk or output is in progress.
// Uses srsw_pkg, srsw_cell and srsw_ctrl.
`default_nettype none
module selective_repeat_sender_window_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire srsw_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output srsw_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);

    srsw_pkg::t_cell_ctl ctl;
    srsw_pkg::t_slot     slots [srsw_pkg::MAX_WINDOW];
    srsw_pkg::t_slot     ring_back;
    logic [srsw_pkg::WIN_W-1:0] win;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        ring_back = slots[0];
        if (ctl.drop) begin
            ring_back.acked     = 1'b0;
            ring_back.sent_time = ctl.now;
        end else if (ctl.restamp) begin
            ring_back.sent_time = ctl.now;
        end
    end

    srsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head_slot (slots[0]),
        .o_ctl       (ctl),
        .o_win       (win)
    );

    for (genvar g = 0; g < srsw_pkg::MAX_WINDOW; g++) begin : g_cell
        srsw_pkg::t_slot next_in;
        if (g == srsw_pkg::MAX_WINDOW - 1) begin : g_tail
            assign next_in = ring_back;
        end else begin : g_mid
            assign next_in = (srsw_pkg::WIN_W'(g) == win - srsw_pkg::WIN_W'(1)) ?
                             ring_back : slots[g+1];
        end
        srsw_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_idx  (srsw_pkg::IDX_W'(g)),
            .i_next (next_in),
            .o_slot (slots[g])
        );
    end

endmodule
`default_nettype wire
